### rtl/hrhi_pkg.sv
// Shared definitions for the HTTP request header indexer.
// Holds field widths, result codes, method text, and the controller/datapath structs.
// Depends on nothing; every other file imports it.
package hrhi_pkg;

  localparam int MAX_HEADERS_DEF   = 16;
  localparam int MESSAGE_BYTES_DEF = 4096;

  localparam int KIND_W  = 3;
  localparam int METH_W  = 3;
  localparam int ENTRY_W = 4;
  localparam int OFF_W   = 12;
  localparam int SPAN_W  = 12;
  localparam int NUM_METH = 5;

  localparam logic [KIND_W-1:0] KIND_REQ_LINE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_HDR_KEY  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HDR_END  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_METH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TBL_FULL = 3'd4;
  localparam logic [KIND_W-1:0] KIND_Q_HIT    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_Q_MISS   = 3'd6;

  localparam logic [METH_W-1:0] METH_GET    = 3'd0;
  localparam logic [METH_W-1:0] METH_POST   = 3'd1;
  localparam logic [METH_W-1:0] METH_PUT    = 3'd2;
  localparam logic [METH_W-1:0] METH_DELETE = 3'd3;
  localparam logic [METH_W-1:0] METH_RESP   = 3'd4;

  localparam logic [7:0]  CH_SP    = 8'h20;
  localparam logic [7:0]  CH_COLON = 8'h3A;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  // Last three bytes before the final LF of a CRLFCRLF terminator.
  localparam logic [23:0] CRLFCR   = 24'h0D0A0D;

  localparam logic [SPAN_W-1:0] RES_CNT_MAX = 12'hFFF;

  typedef struct packed {
    logic [OFF_W-1:0]  off;
    logic [SPAN_W-1:0] len;
    logic [7:0]        first;
    logic [7:0]        sec_last;
    logic [7:0]        last;
  } hdr_entry_t;

  typedef struct packed {
    logic byte_step;
    logic query_start;
    logic tbl_read;
    logic query_cmp;
  } cmd_t;

  typedef struct packed {
    logic out_valid;
    logic tbl_empty;
    logic key_match;
    logic scan_last;
  } status_t;

  // Method text, left aligned in eight characters.
  function automatic logic [63:0] meth_text(input logic [METH_W-1:0] m);
    logic [63:0] t;
    unique case (m)
      METH_GET:    t = {"GET", 40'h0};
      METH_POST:   t = {"POST", 32'h0};
      METH_PUT:    t = {"PUT", 40'h0};
      METH_DELETE: t = {"DELETE", 16'h0};
      METH_RESP:   t = "HTTP/1.1";
      default:     t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] meth_len(input logic [METH_W-1:0] m);
    logic [3:0] n;
    unique case (m)
      METH_GET:    n = 4'd3;
      METH_POST:   n = 4'd4;
      METH_PUT:    n = 4'd3;
      METH_DELETE: n = 4'd6;
      METH_RESP:   n = 4'd8;
      default:     n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] meth_char(input logic [METH_W-1:0] m, input logic [2:0] p);
    logic [63:0] t;
    t = meth_text(m);
    return t[8*(7-int'(p)) +: 8];
  endfunction

endpackage

### rtl/http_request_header_indexer_top.sv
// Top level of the HTTP request header indexer.
// Joins hrhi_ctrl and hrhi_dp; uses hrhi_pkg.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   mode, data_byte, end_of_buffer, query key
//   out_     output     out_valid / out_ready kind, method, entry_index, offset, span
//
// A request byte leaves at most one result in the output register.
// A query walks the key table through its single read port, reading then comparing each slot;
// it stops at the first hit or after the last key, and an empty table answers at once.
// in_ready is low during a query walk and while a held result is not being taken.
// Reset (rst_n low at a clock edge) clears the parse state and key count, not the table.
module http_request_header_indexer_top #(
  parameter int MAX_HEADERS   = hrhi_pkg::MAX_HEADERS_DEF,
  parameter int MESSAGE_BYTES = hrhi_pkg::MESSAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_mode,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_end_of_buffer,
  input  logic [7:0]                   in_query_length,
  input  logic [7:0]                   in_query_first,
  input  logic [7:0]                   in_query_second_last,
  input  logic [7:0]                   in_query_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [hrhi_pkg::KIND_W-1:0]  out_kind,
  output logic [hrhi_pkg::METH_W-1:0]  out_method,
  output logic [hrhi_pkg::ENTRY_W-1:0] out_entry_index,
  output logic [hrhi_pkg::OFF_W-1:0]   out_offset,
  output logic [hrhi_pkg::SPAN_W-1:0]  out_span
);
  import hrhi_pkg::*;

  cmd_t    cmd;
  status_t status;

  hrhi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  hrhi_dp #(
    .MAX_HEADERS   (MAX_HEADERS),
    .MESSAGE_BYTES (MESSAGE_BYTES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_data_byte         (in_data_byte),
    .in_end_of_buffer     (in_end_of_buffer),
    .in_query_length      (in_query_length),
    .in_query_first       (in_query_first),
    .in_query_second_last (in_query_second_last),
    .in_query_last        (in_query_last),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_kind             (out_kind),
    .out_method           (out_method),
    .out_entry_index      (out_entry_index),
    .out_offset           (out_offset),
    .out_span             (out_span)
  );

endmodule

### rtl/hrhi_ctrl.sv
// Controller for the HTTP request header indexer: input handshake and key table scan.
// Issues commands to hrhi_dp and reads its status; uses hrhi_pkg.
module hrhi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  logic              out_ready,
  input  hrhi_pkg::status_t status,
  output hrhi_pkg::cmd_t    cmd
);
  import hrhi_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP
  } state_t;

  state_t state_r;
  logic   out_free;
  logic   accept;

  assign out_free = !status.out_valid || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.byte_step   = accept && !in_mode;
    cmd.query_start = accept && in_mode;
    cmd.tbl_read    = (state_r == ST_READ);
    cmd.query_cmp   = (state_r == ST_CMP) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          // An empty table answers at once; otherwise walk it slot by slot.
          if (cmd.query_start && !status.tbl_empty) begin
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (cmd.query_cmp) begin
            if (status.key_match || status.scan_last) begin
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/hrhi_dp.sv
// Datapath for the HTTP request header indexer: parse state, key table memory,
// query compare and the result register. Driven by hrhi_ctrl; uses hrhi_pkg.
module hrhi_dp #(
  parameter int MAX_HEADERS   = hrhi_pkg::MAX_HEADERS_DEF,
  parameter int MESSAGE_BYTES = hrhi_pkg::MESSAGE_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hrhi_pkg::cmd_t               cmd,
  output hrhi_pkg::status_t            status,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_end_of_buffer,
  input  logic [7:0]                   in_query_length,
  input  logic [7:0]                   in_query_first,
  input  logic [7:0]                   in_query_second_last,
  input  logic [7:0]                   in_query_last,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [hrhi_pkg::KIND_W-1:0]  out_kind,
  output logic [hrhi_pkg::METH_W-1:0]  out_method,
  output logic [hrhi_pkg::ENTRY_W-1:0] out_entry_index,
  output logic [hrhi_pkg::OFF_W-1:0]   out_offset,
  output logic [hrhi_pkg::SPAN_W-1:0]  out_span
);
  import hrhi_pkg::*;

  localparam int POS_W = $clog2(MESSAGE_BYTES + 1);
  localparam int CNT_W = $clog2(MAX_HEADERS + 1);
  localparam int IDX_W = $clog2(MAX_HEADERS);

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SKIP,
    PH_RESOURCE,
    PH_LINE,
    PH_HEADERS,
    PH_DONE,
    PH_BAD
  } phase_t;

  // Parse state.
  logic [POS_W-1:0]    pos_r, pos_nxt;
  phase_t              phase_r, phase_nxt;
  logic [NUM_METH-1:0] cand_r, cand_nxt;
  logic [SPAN_W-1:0]   res_cnt_r, res_cnt_nxt;
  logic [POS_W-1:0]    line_start_r, line_start_nxt;
  logic [23:0]         recent_r, recent_nxt;
  logic [CNT_W-1:0]    hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]          line_first_r, line_first_nxt;

  // Key table and query.
  hdr_entry_t          tbl_mem [MAX_HEADERS];
  hdr_entry_t          rd_r;
  logic [IDX_W-1:0]    scan_idx_r;
  logic [7:0]          q_len_r, q_first_r, q_sec_last_r, q_last_r;

  // Byte step results.
  logic [CNT_W-1:0]    hc_eff;
  logic [POS_W-1:0]    klen;
  logic [NUM_METH-1:0] cand_live;
  logic                hit_found;
  logic [METH_W-1:0]   hit_idx;
  logic [METH_W-1:0]   cur_meth;
  logic                wr_en;
  hdr_entry_t          wr_entry;
  logic                b_emit;
  logic [KIND_W-1:0]   b_kind;
  logic [METH_W-1:0]   b_meth;
  logic [ENTRY_W-1:0]  b_idx;
  logic [OFF_W-1:0]    b_off;
  logic [SPAN_W-1:0]   b_span;

  // Result register load.
  logic                ld;
  logic [KIND_W-1:0]   ld_kind;
  logic [METH_W-1:0]   ld_meth;
  logic [ENTRY_W-1:0]  ld_idx;
  logic [OFF_W-1:0]    ld_off;
  logic [SPAN_W-1:0]   ld_span;

  logic                out_valid_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [METH_W-1:0]   out_meth_r;
  logic [ENTRY_W-1:0]  out_idx_r;
  logic [OFF_W-1:0]    out_off_r;
  logic [SPAN_W-1:0]   out_span_r;

  // Method of the one live candidate, lowest first.
  always_comb begin
    cur_meth = METH_GET;
    for (int i = NUM_METH - 1; i >= 0; i--) begin
      if (cand_r[i]) begin
        cur_meth = METH_W'(i);
      end
    end
  end

  always_comb begin
    pos_nxt        = pos_r;
    phase_nxt      = phase_r;
    cand_nxt       = cand_r;
    res_cnt_nxt    = res_cnt_r;
    line_start_nxt = line_start_r;
    recent_nxt     = recent_r;
    line_first_nxt = line_first_r;
    wr_en          = 1'b0;
    wr_entry       = '0;
    b_emit         = 1'b0;
    b_kind         = KIND_REQ_LINE;
    b_meth         = METH_GET;
    b_idx          = '0;
    b_off          = '0;
    b_span         = '0;
    cand_live      = '0;
    hit_found      = 1'b0;
    hit_idx        = METH_GET;

    // The first byte of a message clears the previous message's key count.
    hc_eff      = (pos_r == '0) ? '0 : hdr_cnt_r;
    hdr_cnt_nxt = hc_eff;
    klen        = pos_r - POS_W'(1) - line_start_r;

    for (int i = 0; i < NUM_METH; i++) begin
      cand_live[i] = cand_r[i] && (pos_r < POS_W'(meth_len(METH_W'(i))))
                     && (meth_char(METH_W'(i), pos_r[2:0]) == in_data_byte);
    end
    for (int i = 0; i < NUM_METH; i++) begin
      if (!hit_found && cand_live[i]
          && (POS_W'(meth_len(METH_W'(i))) == pos_r + POS_W'(1))) begin
        hit_found = 1'b1;
        hit_idx   = METH_W'(i);
      end
    end

    if (pos_r < POS_W'(MESSAGE_BYTES)) begin
      unique case (phase_r)
        PH_METHOD: begin
          if (hit_found) begin
            cand_nxt  = NUM_METH'(1) << hit_idx;
            phase_nxt = PH_SKIP;
          end else if (cand_live == '0) begin
            cand_nxt  = '0;
            phase_nxt = PH_BAD;
            b_emit    = 1'b1;
            b_kind    = KIND_BAD_METH;
          end else begin
            cand_nxt = cand_live;
          end
        end
        PH_SKIP: begin
          line_start_nxt = pos_r + POS_W'(1);
          res_cnt_nxt    = '0;
          phase_nxt      = PH_RESOURCE;
        end
        PH_RESOURCE: begin
          if (in_data_byte == CH_SP) begin
            b_emit    = 1'b1;
            b_kind    = KIND_REQ_LINE;
            b_meth    = cur_meth;
            b_off     = OFF_W'(line_start_r);
            b_span    = res_cnt_r;
            phase_nxt = PH_LINE;
          end else if (res_cnt_r != RES_CNT_MAX) begin
            res_cnt_nxt = res_cnt_r + SPAN_W'(1);
          end
        end
        PH_LINE: begin
          if (in_data_byte == CH_LF) begin
            line_start_nxt = pos_r + POS_W'(1);
            phase_nxt      = PH_HEADERS;
          end
        end
        PH_HEADERS: begin
          if (pos_r == line_start_r) begin
            line_first_nxt = in_data_byte;
          end
          if (in_data_byte == CH_LF) begin
            if (recent_r == CRLFCR) begin
              phase_nxt = PH_DONE;
              b_emit    = 1'b1;
              b_kind    = KIND_HDR_END;
              b_off     = OFF_W'(pos_r + POS_W'(1));
            end else begin
              line_start_nxt = pos_r + POS_W'(1);
            end
          end else if (in_data_byte == CH_SP && recent_r[7:0] == CH_COLON) begin
            b_emit = 1'b1;
            if (hc_eff < CNT_W'(MAX_HEADERS)) begin
              wr_en             = 1'b1;
              wr_entry.off      = OFF_W'(line_start_r);
              wr_entry.len      = SPAN_W'(klen);
              wr_entry.first    = line_first_r;
              wr_entry.sec_last = recent_r[23:16];
              wr_entry.last     = recent_r[15:8];
              hdr_cnt_nxt       = hc_eff + CNT_W'(1);
              b_kind            = KIND_HDR_KEY;
              b_idx             = ENTRY_W'(hc_eff);
              b_off             = OFF_W'(line_start_r);
              b_span            = SPAN_W'(klen);
            end else begin
              b_kind = KIND_TBL_FULL;
            end
          end
        end
        PH_DONE, PH_BAD: begin
        end
        default: begin
        end
      endcase
      recent_nxt = {recent_r[15:0], in_data_byte};
      pos_nxt    = pos_r + POS_W'(1);
    end

    if (in_end_of_buffer) begin
      pos_nxt        = '0;
      phase_nxt      = PH_METHOD;
      cand_nxt       = '1;
      res_cnt_nxt    = '0;
      line_start_nxt = '0;
      recent_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      phase_r      <= PH_METHOD;
      cand_r       <= '1;
      res_cnt_r    <= '0;
      line_start_r <= '0;
      recent_r     <= '0;
      hdr_cnt_r    <= '0;
      line_first_r <= '0;
    end else if (cmd.byte_step) begin
      pos_r        <= pos_nxt;
      phase_r      <= phase_nxt;
      cand_r       <= cand_nxt;
      res_cnt_r    <= res_cnt_nxt;
      line_start_r <= line_start_nxt;
      recent_r     <= recent_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      line_first_r <= line_first_nxt;
    end
  end

  // Key table: one write port for recording, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.byte_step && wr_en) begin
      tbl_mem[hc_eff[IDX_W-1:0]] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tbl_read) begin
      rd_r <= tbl_mem[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
    end else if (cmd.query_start) begin
      scan_idx_r <= '0;
    end else if (cmd.query_cmp && !status.key_match && !status.scan_last) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      q_len_r      <= in_query_length;
      q_first_r    <= in_query_first;
      q_sec_last_r <= in_query_second_last;
      q_last_r     <= in_query_last;
    end
  end

  always_comb begin
    status.out_valid = out_valid_r;
    status.tbl_empty = (hdr_cnt_r == '0);
    status.key_match = (rd_r.len == SPAN_W'(q_len_r)) && (rd_r.first == q_first_r)
                       && (rd_r.sec_last == q_sec_last_r) && (rd_r.last == q_last_r);
    status.scan_last = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == hdr_cnt_r);
  end

  always_comb begin
    ld      = 1'b0;
    ld_kind = KIND_Q_MISS;
    ld_meth = METH_GET;
    ld_idx  = '0;
    ld_off  = '0;
    ld_span = '0;
    priority if (cmd.byte_step) begin
      ld      = b_emit;
      ld_kind = b_kind;
      ld_meth = b_meth;
      ld_idx  = b_idx;
      ld_off  = b_off;
      ld_span = b_span;
    end else if (cmd.query_start) begin
      ld = status.tbl_empty;
    end else if (cmd.query_cmp) begin
      if (status.key_match) begin
        ld      = 1'b1;
        ld_kind = KIND_Q_HIT;
        ld_idx  = ENTRY_W'(scan_idx_r);
        ld_off  = rd_r.off + rd_r.len + OFF_W'(2);
        ld_span = rd_r.len;
      end else begin
        ld = status.scan_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_kind_r <= ld_kind;
      out_meth_r <= ld_meth;
      out_idx_r  <= ld_idx;
      out_off_r  <= ld_off;
      out_span_r <= ld_span;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_method      = out_meth_r;
  assign out_entry_index = out_idx_r;
  assign out_offset      = out_off_r;
  assign out_span        = out_span_r;

endmodule
